// ----- src/mpba_pkg.sv -----
// Shared constants, types and codes for the multi-pool block allocator.
`default_nettype none
package mpba_pkg;

  // Pool geometry.
  localparam int NUM_POOLS       = 4;
  localparam int CHUNKS_PER_POOL = 16;
  localparam int POOL_W          = 2;
  localparam int CHUNK_W         = 4;
  localparam int FILL_W          = 5;
  localparam int ENTRIES         = NUM_POOLS * CHUNKS_PER_POOL;
  localparam int ADDR_W          = $clog2(ENTRIES);

  // Field widths.
  localparam int SIZE_W   = 16;
  localparam int REQ_W    = 32;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;

  // Configuration register map.
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int REG_SIZE_BASE  = 0;
  localparam int REG_COUNT_BASE = 4;
  localparam int NUM_REGS       = 8;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_NOT_TAKEN  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_state_t;

  // Configuration view handed to the controller.
  typedef struct packed {
    logic [NUM_POOLS-1:0][SIZE_W-1:0] size;
    logic [NUM_POOLS-1:0][FILL_W-1:0] count;
    logic [NUM_POOLS-1:0][FILL_W-1:0] count_next;
    logic                             rebuild;
  } cfg_state_t;

endpackage
`default_nettype wire

// ----- src/mpba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpba_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/mpba_cfg_regs.sv -----
// Configuration registers: chunk sizes and chunk counts of each pool.
`default_nettype none
module mpba_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic [mpba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mpba_pkg::CFG_DATA_W-1:0]      cfg_data,
  output mpba_pkg::cfg_state_t                      cfg
);

  logic [mpba_pkg::NUM_POOLS-1:0][mpba_pkg::SIZE_W-1:0] size, size_next;
  logic [mpba_pkg::NUM_POOLS-1:0][mpba_pkg::FILL_W-1:0] count, count_reg_next;
  logic                                                 hit_size, hit_count;

  // Register decode.
  always_comb begin
    hit_size  = cfg_valid && (32'(cfg_index) < mpba_pkg::REG_COUNT_BASE);
    hit_count = cfg_valid && (32'(cfg_index) >= mpba_pkg::REG_COUNT_BASE) &&
                (32'(cfg_index) < mpba_pkg::NUM_REGS);
    size_next      = size;
    count_reg_next = count;
    if (hit_size) begin
      size_next[cfg_index[mpba_pkg::POOL_W-1:0]] = cfg_data[mpba_pkg::SIZE_W-1:0];
    end
    if (hit_count) begin
      count_reg_next[cfg_index[mpba_pkg::POOL_W-1:0]] = cfg_data[mpba_pkg::FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size  <= '0;
      count <= '0;
    end else begin
      size  <= size_next;
      count <= count_reg_next;
    end
  end

  // Effective counts saturate at the pool capacity.
  always_comb begin
    cfg.size    = size;
    cfg.rebuild = hit_size || hit_count;
    for (int p = 0; p < mpba_pkg::NUM_POOLS; p++) begin
      cfg.count[p] = (32'(count[p]) > mpba_pkg::CHUNKS_PER_POOL) ?
                     mpba_pkg::FILL_W'(mpba_pkg::CHUNKS_PER_POOL) : count[p];
      cfg.count_next[p] = (32'(count_reg_next[p]) > mpba_pkg::CHUNKS_PER_POOL) ?
                          mpba_pkg::FILL_W'(mpba_pkg::CHUNKS_PER_POOL) : count_reg_next[p];
    end
  end

endmodule
`default_nettype wire

// ----- src/multi_pool_block_allocator.sv -----
// Multi-pool fixed-size block allocator: one transaction in, one result out.
// Each transaction is captured at accept and executed once the output register is free.
// No new transaction is taken until the last one has executed, due to the read-modify-write of the
// free-queue memory (read in the accept cycle, written back in the execute cycle).
// Reset clears counters, configuration, queue pointers and the per-entry valid bits,
// so both memories read as rebuilt at once; there is no clearing pass.
`default_nettype none
module multi_pool_block_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mpba_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mpba_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Request channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              cmd,
  input  wire logic [mpba_pkg::REQ_W-1:0]        request_size,
  input  wire logic [mpba_pkg::POOL_W-1:0]       free_pool,
  input  wire logic [mpba_pkg::CHUNK_W-1:0]      free_chunk,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mpba_pkg::STATUS_W-1:0]          status,
  output logic [mpba_pkg::POOL_W-1:0]            got_pool,
  output logic [mpba_pkg::CHUNK_W-1:0]           got_chunk,
  output logic [mpba_pkg::COUNT_W-1:0]           alloc_total,
  output logic [mpba_pkg::COUNT_W-1:0]           free_total
);

  mpba_pkg::cfg_state_t cfg;
  mpba_pkg::fsm_state_t state, state_next;

  logic [mpba_pkg::NUM_POOLS-1:0][mpba_pkg::CHUNK_W-1:0] head;
  logic [mpba_pkg::NUM_POOLS-1:0][mpba_pkg::FILL_W-1:0]  fill;
  logic [mpba_pkg::ENTRIES-1:0]                          q_vld, t_vld;
  logic [mpba_pkg::COUNT_W-1:0]                          alloc_counter, free_counter;

  logic accept, exec_go;

  // Accept-cycle decisions.
  logic [mpba_pkg::NUM_POOLS-1:0] fit;
  logic [mpba_pkg::POOL_W-1:0]    sel_pool;
  logic                           found, bad;
  logic [mpba_pkg::FILL_W-1:0]    tail_sum;
  logic [mpba_pkg::ADDR_W-1:0]    q_raddr, t_raddr;

  // Registered operation.
  logic                         op_cmd, op_ok, q_hit, t_hit;
  logic [mpba_pkg::POOL_W-1:0]  op_pool;
  logic [mpba_pkg::CHUNK_W-1:0] op_chunk, op_slot;

  // Execute-cycle signals.
  logic [mpba_pkg::CHUNK_W-1:0] q_rdata, alloc_chunk;
  logic [0:0]                   t_rdata, t_wdata;
  logic                         taken, commit_alloc, commit_free;
  logic                         q_we, t_we;
  logic [mpba_pkg::ADDR_W-1:0]  q_waddr, t_waddr;
  mpba_pkg::status_t            res_status;

  mpba_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mpba_pkg::S_IDLE: if (in_valid) state_next = mpba_pkg::S_EXEC;
      mpba_pkg::S_EXEC: if (!out_valid || out_ready) state_next = mpba_pkg::S_IDLE;
      default:          state_next = mpba_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    unique case (state)
      mpba_pkg::S_IDLE: in_ready = 1'b1;
      mpba_pkg::S_EXEC: exec_go  = !out_valid || out_ready;
      default:          in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Pool search for allocate, handle check and tail slot for free.
  always_comb begin
    for (int p = 0; p < mpba_pkg::NUM_POOLS; p++) begin
      fit[p] = (request_size[mpba_pkg::REQ_W-1:mpba_pkg::SIZE_W] == '0) &&
               (cfg.size[p] >= request_size[mpba_pkg::SIZE_W-1:0]) &&
               (fill[p] != '0);
    end
    sel_pool = '0;
    for (int p = mpba_pkg::NUM_POOLS - 1; p >= 0; p--) begin
      if (fit[p]) sel_pool = mpba_pkg::POOL_W'(p);
    end
    found    = |fit;
    bad      = mpba_pkg::FILL_W'(free_chunk) >= cfg.count[free_pool];
    tail_sum = mpba_pkg::FILL_W'(head[free_pool]) + fill[free_pool];
    if (32'(tail_sum) >= mpba_pkg::CHUNKS_PER_POOL) begin
      tail_sum = tail_sum - mpba_pkg::FILL_W'(mpba_pkg::CHUNKS_PER_POOL);
    end
    q_raddr = {sel_pool, head[sel_pool]};
    t_raddr = {free_pool, free_chunk};
  end

  // Capture the operation at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd   <= cmd;
      op_chunk <= free_chunk;
      q_hit    <= q_vld[q_raddr];
      t_hit    <= t_vld[t_raddr];
      if (cmd == mpba_pkg::CMD_ALLOC) begin
        op_pool <= sel_pool;
        op_slot <= head[sel_pool];
        op_ok   <= found;
      end else begin
        op_pool <= free_pool;
        op_slot <= tail_sum[mpba_pkg::CHUNK_W-1:0];
        op_ok   <= !bad;
      end
    end
  end

  // Free-queue memory: chunk index held in each queue slot.
  mpba_ram #(
    .WIDTH (mpba_pkg::CHUNK_W),
    .DEPTH (mpba_pkg::ENTRIES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (op_chunk),
    .re    (accept),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Taken-mark memory, one bit per chunk.
  mpba_ram #(
    .WIDTH (1),
    .DEPTH (mpba_pkg::ENTRIES)
  ) u_taken_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (accept),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Execute: an unwritten queue slot holds its own index, an unwritten mark is clear.
  always_comb begin
    alloc_chunk  = q_hit ? q_rdata : op_slot;
    taken        = t_hit && t_rdata[0];
    commit_alloc = 1'b0;
    commit_free  = 1'b0;
    res_status   = mpba_pkg::ST_OK;
    case (op_cmd)
      mpba_pkg::CMD_ALLOC: begin
        if (op_ok) commit_alloc = 1'b1;
        else       res_status   = mpba_pkg::ST_NO_FIT;
      end
      mpba_pkg::CMD_FREE: begin
        if (!op_ok)      res_status  = mpba_pkg::ST_BAD_HANDLE;
        else if (!taken) res_status  = mpba_pkg::ST_NOT_TAKEN;
        else             commit_free = 1'b1;
      end
      default: res_status = mpba_pkg::ST_OK;
    endcase
    q_we    = exec_go && commit_free;
    q_waddr = {op_pool, op_slot};
    t_we    = exec_go && (commit_alloc || commit_free);
    t_waddr = commit_alloc ? {op_pool, alloc_chunk} : {op_pool, op_chunk};
    t_wdata = commit_alloc;
  end

  // Valid bits, queue pointers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld         <= '0;
      t_vld         <= '0;
      head          <= '0;
      fill          <= '0;
      alloc_counter <= '0;
      free_counter  <= '0;
    end else if (cfg.rebuild) begin
      q_vld <= '0;
      t_vld <= '0;
      head  <= '0;
      fill  <= cfg.count_next;
    end else begin
      if (q_we) q_vld[q_waddr] <= 1'b1;
      if (t_we) t_vld[t_waddr] <= 1'b1;
      if (exec_go && commit_alloc) begin
        head[op_pool] <= (32'(head[op_pool]) == mpba_pkg::CHUNKS_PER_POOL - 1) ?
                         '0 : head[op_pool] + 1'b1;
        fill[op_pool] <= fill[op_pool] - 1'b1;
        alloc_counter <= alloc_counter + 1'b1;
      end
      if (exec_go && commit_free) begin
        if (32'(fill[op_pool]) < mpba_pkg::CHUNKS_PER_POOL) begin
          fill[op_pool] <= fill[op_pool] + 1'b1;
        end
        free_counter <= free_counter + 1'b1;
      end
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: result payload.
  always_ff @(posedge clk) begin
    if (exec_go) begin
      status      <= res_status;
      got_pool    <= commit_alloc ? op_pool : '0;
      got_chunk   <= commit_alloc ? alloc_chunk : '0;
      alloc_total <= commit_alloc ? alloc_counter + 1'b1 : alloc_counter;
      free_total  <= commit_free ? free_counter + 1'b1 : free_counter;
    end
  end

endmodule
`default_nettype wire
